FILE: rtl/core/msae_pkg.sv
// Shared constants, types and helpers of the mail sender address extractor.
`default_nettype none
package msae_pkg;

  localparam int MAX_ADDRESS_LEN  = 60;
  localparam int MAX_COMMENT_NEST = 15;
  localparam int ROOT_LEN         = 4;
  localparam int Q_DEPTH          = 4;

  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 6;
  localparam int DEPTH_W = 4;
  localparam int PH_W    = 3;
  localparam int QCNT_W  = 3;
  localparam int POS_W   = 7;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3a;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3c;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
  localparam logic [CHAR_W-1:0] CH_O      = 8'h6f;

  // lookahead phases after a space
  localparam logic [PH_W-1:0] PH_NONE        = 3'd0;
  localparam logic [PH_W-1:0] PH_SPACE       = 3'd1;
  localparam logic [PH_W-1:0] PH_SPACE_A     = 3'd2;
  localparam logic [PH_W-1:0] PH_SPACE_AT    = 3'd3;
  localparam logic [PH_W-1:0] PH_SPACE_ATSGN = 3'd4;

  typedef struct packed {
    logic accept;
    logic store;
    logic load;
    logic advance;
    logic finish;
  } msae_cmd_t;

  typedef struct packed {
    logic has_stores;
    logic field_end;
    logic q_last;
    logic end_pending;
    logic out_last;
  } msae_sts_t;

  typedef struct packed {
    logic [2:0][CHAR_W-1:0] ch;
    logic [1:0]             n;
  } rel_t;

  // characters held by an unfinished lookahead, in store order
  function automatic rel_t release_chars(input logic [PH_W-1:0] ph);
    rel_t r;
    r = '0;
    case (ph)
      PH_SPACE_A: begin
        r.ch[0] = CH_SPACE;
        r.ch[1] = CH_A;
        r.n     = 2'd2;
      end
      PH_SPACE_AT: begin
        r.ch[0] = CH_SPACE;
        r.ch[1] = CH_A;
        r.ch[2] = CH_T;
        r.n     = 2'd3;
      end
      PH_SPACE_ATSGN: begin
        r.ch[0] = CH_SPACE;
        r.ch[1] = CH_AT;
        r.n     = 2'd2;
      end
      default: r.n = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] root_char(input logic [1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      2'd0:    c = CH_R;
      2'd1:    c = CH_O;
      2'd2:    c = CH_O;
      default: c = CH_T;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/msae_ifs.sv
// Valid/ready channel interfaces for header characters and address characters.
`default_nettype none
interface msae_hdr_if;
  logic                          valid;
  logic                          ready;
  logic [msae_pkg::CHAR_W-1:0]   char_in;
  logic                          end_of_field;

  modport source (output valid, output char_in, output end_of_field, input ready);
  modport sink   (input valid, input char_in, input end_of_field, output ready);
endinterface

interface msae_addr_if;
  logic                          valid;
  logic                          ready;
  logic [msae_pkg::CHAR_W-1:0]   char_out;
  logic                          last_char;
  logic                          empty_address;
  logic                          truncated;

  modport source (output valid, output char_out, output last_char,
                  output empty_address, output truncated, input ready);
  modport sink   (input valid, input char_out, input last_char,
                  input empty_address, input truncated, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/msae_ctrl.sv
// Sequencer: request intake, buffer stores and address readout.
`default_nettype none
module msae_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                out_ready,
  input  wire msae_pkg::msae_sts_t sts,
  output msae_pkg::msae_cmd_t      cmd,
  output logic                     in_ready,
  output logic                     out_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STORE = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.has_stores) begin
            state_next = S_STORE;
          end else if (sts.field_end) begin
            state_next = S_FETCH;
          end
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (sts.q_last) begin
          state_next = sts.end_pending ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/msae_dp.sv
// Datapath: header parsing, store queue, address buffer and readout registers.
`default_nettype none
module msae_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire msae_pkg::msae_cmd_t             cmd,
  output msae_pkg::msae_sts_t                  sts,
  input  wire logic [msae_pkg::CHAR_W-1:0]     char_in,
  input  wire logic                            end_of_field,
  output logic [msae_pkg::CHAR_W-1:0]          char_out,
  output logic                                 last_char,
  output logic                                 empty_address,
  output logic                                 truncated
);

  localparam int CW = msae_pkg::CHAR_W;

  // parser state
  logic [msae_pkg::LEN_W-1:0]   len;
  logic                         angle;
  logic                         space;
  logic [msae_pkg::PH_W-1:0]    phase;
  logic [msae_pkg::DEPTH_W-1:0] depth;
  logic                         skip;
  logic                         fin;
  logic                         colon;
  logic                         ovf;
  logic                         first_at;

  // store queue
  logic [CW-1:0]                qdata [msae_pkg::Q_DEPTH];
  logic [msae_pkg::QCNT_W-1:0]  qcount;
  logic                         clr_pending;
  logic                         end_pending;

  // readout
  logic [CW-1:0]                mem [msae_pkg::MAX_ADDRESS_LEN];
  logic [CW-1:0]                rdata;
  logic [msae_pkg::POS_W-1:0]   pos;
  logic [msae_pkg::LEN_W-1:0]   raddr;
  logic [msae_pkg::POS_W-1:0]   total;
  logic                         prefix;

  // step results
  logic                         skip_next;
  logic [msae_pkg::DEPTH_W-1:0] depth_next;
  logic [msae_pkg::PH_W-1:0]    phase_next;
  logic                         space_next;
  logic                         angle_next;
  logic                         fin_next;
  logic                         clr_next;
  logic [CW-1:0]                st_q [msae_pkg::Q_DEPTH];
  logic [msae_pkg::QCNT_W-1:0]  st_n;
  logic [CW-1:0]                q_next [msae_pkg::Q_DEPTH];
  logic [msae_pkg::QCNT_W-1:0]  qcount_next;
  logic                         disp;
  logic                         sp;
  logic                         matched;
  msae_pkg::rel_t               rel_a;
  msae_pkg::rel_t               rel_e;

  assign rel_a = msae_pkg::release_chars(phase);
  assign rel_e = msae_pkg::release_chars(phase_next);

  always_comb begin
    skip_next  = skip;
    depth_next = depth;
    phase_next = phase;
    space_next = space;
    angle_next = angle;
    fin_next   = fin;
    clr_next   = 1'b0;
    st_n       = '0;
    disp       = 1'b0;
    sp         = space;
    matched    = 1'b0;
    for (int i = 0; i < msae_pkg::Q_DEPTH; i++) begin
      st_q[i] = '0;
    end
    if (!fin && char_in != msae_pkg::CH_NUL) begin
      if (skip) begin
        skip_next = 1'b0;
      end else if (depth != '0) begin
        if (char_in == msae_pkg::CH_LPAREN) begin
          if (depth < msae_pkg::DEPTH_W'(msae_pkg::MAX_COMMENT_NEST)) begin
            depth_next = depth + 1'b1;
          end
        end else if (char_in == msae_pkg::CH_RPAREN) begin
          depth_next = depth - 1'b1;
          if (depth == msae_pkg::DEPTH_W'(1)) begin
            skip_next = 1'b1;
          end
        end
      end else if (phase != msae_pkg::PH_NONE) begin
        if (phase == msae_pkg::PH_SPACE) begin
          if (char_in == msae_pkg::CH_A) begin
            phase_next = msae_pkg::PH_SPACE_A;
            matched    = 1'b1;
          end else if (char_in == msae_pkg::CH_AT) begin
            phase_next = msae_pkg::PH_SPACE_ATSGN;
            matched    = 1'b1;
          end
        end else if (phase == msae_pkg::PH_SPACE_A) begin
          if (char_in == msae_pkg::CH_T) begin
            phase_next = msae_pkg::PH_SPACE_AT;
            matched    = 1'b1;
          end
        end else if (char_in == msae_pkg::CH_SPACE) begin
          phase_next = msae_pkg::PH_NONE;
          st_q[0]    = msae_pkg::CH_AT;
          st_n       = 3'd1;
          matched    = 1'b1;
        end
        if (!matched) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < rel_a.n) begin
              st_q[st_n[1:0]] = rel_a.ch[i];
              st_n            = st_n + 3'd1;
            end
          end
          phase_next = msae_pkg::PH_NONE;
          sp         = (phase == msae_pkg::PH_SPACE);
          space_next = sp;
          disp       = 1'b1;
        end
      end else begin
        disp = 1'b1;
      end
      if (disp) begin
        case (char_in)
          msae_pkg::CH_LPAREN: begin
            depth_next = msae_pkg::DEPTH_W'(1);
            space_next = 1'b0;
          end
          msae_pkg::CH_SPACE: begin
            phase_next = msae_pkg::PH_SPACE;
          end
          msae_pkg::CH_LT: begin
            clr_next   = 1'b1;
            angle_next = 1'b1;
            space_next = 1'b0;
          end
          default: begin
            if (char_in == msae_pkg::CH_GT && angle) begin
              fin_next = 1'b1;
            end else begin
              if (sp) begin
                st_q[st_n[1:0]] = msae_pkg::CH_SPACE;
                st_n            = st_n + 3'd1;
              end
              st_q[st_n[1:0]] = char_in;
              st_n            = st_n + 3'd1;
              space_next      = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // held lookahead characters are flushed at the end of the field
  always_comb begin
    qcount_next = st_n;
    for (int i = 0; i < msae_pkg::Q_DEPTH; i++) begin
      q_next[i] = st_q[i];
    end
    if (end_of_field && !fin_next) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < rel_e.n) begin
          q_next[qcount_next[1:0]] = rel_e.ch[i];
          qcount_next              = qcount_next + 3'd1;
        end
      end
    end
  end

  assign prefix = first_at && !colon;
  assign total  = {1'b0, len} + (prefix ? msae_pkg::POS_W'(msae_pkg::ROOT_LEN) : '0);
  assign raddr  = pos[msae_pkg::LEN_W-1:0]
                - (prefix ? msae_pkg::LEN_W'(msae_pkg::ROOT_LEN) : '0);

  assign sts.has_stores  = (qcount_next != '0);
  assign sts.field_end   = end_of_field;
  assign sts.q_last      = (qcount == msae_pkg::QCNT_W'(1));
  assign sts.end_pending = end_pending;
  assign sts.out_last    = last_char;

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      len         <= '0;
      angle       <= 1'b0;
      space       <= 1'b0;
      phase       <= msae_pkg::PH_NONE;
      depth       <= '0;
      skip        <= 1'b0;
      fin         <= 1'b0;
      colon       <= 1'b0;
      ovf         <= 1'b0;
      qcount      <= '0;
      clr_pending <= 1'b0;
      end_pending <= 1'b0;
    end else if (cmd.accept) begin
      skip        <= skip_next;
      depth       <= depth_next;
      phase       <= phase_next;
      space       <= space_next;
      angle       <= angle_next;
      fin         <= fin_next;
      qcount      <= qcount_next;
      end_pending <= end_of_field;
      if (qcount_next == '0 && clr_next) begin
        len         <= '0;
        colon       <= 1'b0;
        ovf         <= 1'b0;
        clr_pending <= 1'b0;
      end else begin
        clr_pending <= clr_next;
      end
    end else if (cmd.store) begin
      qcount <= qcount - 1'b1;
      if (qcount == msae_pkg::QCNT_W'(1) && clr_pending) begin
        len         <= '0;
        colon       <= 1'b0;
        ovf         <= 1'b0;
        clr_pending <= 1'b0;
      end else begin
        if (qdata[0] == msae_pkg::CH_COLON) begin
          colon <= 1'b1;
        end
        if (len < msae_pkg::LEN_W'(msae_pkg::MAX_ADDRESS_LEN)) begin
          len <= len + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < msae_pkg::Q_DEPTH; i++) begin
        qdata[i] <= q_next[i];
      end
      pos <= '0;
    end else if (cmd.store) begin
      for (int i = 0; i < msae_pkg::Q_DEPTH - 1; i++) begin
        qdata[i] <= qdata[i+1];
      end
      if (len == '0) begin
        first_at <= (qdata[0] == msae_pkg::CH_AT);
      end
    end else if (cmd.advance) begin
      pos <= pos + 1'b1;
    end
    if (cmd.load) begin
      truncated <= ovf;
      if (len == '0) begin
        char_out      <= msae_pkg::CH_NUL;
        last_char     <= 1'b1;
        empty_address <= 1'b1;
      end else begin
        empty_address <= 1'b0;
        last_char     <= (pos + 1'b1 == total);
        if (prefix && pos < msae_pkg::POS_W'(msae_pkg::ROOT_LEN)) begin
          char_out <= msae_pkg::root_char(pos[1:0]);
        end else begin
          char_out <= rdata;
        end
      end
    end
  end

  // address buffer
  always_ff @(posedge clk) begin
    if (cmd.store && len < msae_pkg::LEN_W'(msae_pkg::MAX_ADDRESS_LEN)) begin
      mem[len] <= qdata[0];
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/mail_sender_address_extractor_unit.sv
// Top level of the mail sender address extractor.
//
// hdr takes one header-field character per request; end_of_field marks the
// last one. addr returns the extracted sender address one character per
// request, last_char on its final character, or a single request with
// empty_address set when nothing was collected; truncated repeats the
// buffer overflow flag on each.
// An accepted character is followed by one store state per buffer write it
// causes (0 to 4; a failed "at"/"@" lookahead replays the held
// characters), since the address buffer has a single write port.
// After the field's last character each address character goes through a
// buffer read, an output load and a hand-over held for receiver stalls;
// "root" is sent first when the address starts with '@' and has no colon.
// hdr is not ready while stores or the readout run. A stalled receiver
// holds the current character in the output register.
// Reset clears all parsing state; the buffer itself needs no clearing pass.
// After the final address character is taken the block returns to idle
// with reset state, ready for the next field.
`default_nettype none
module mail_sender_address_extractor_unit (
  input wire logic   clk,
  input wire logic   rst,
  msae_hdr_if.sink   hdr,
  msae_addr_if.source addr
);

  msae_pkg::msae_cmd_t cmd;
  msae_pkg::msae_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  msae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hdr.valid),
    .out_ready (addr.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  msae_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .char_in       (hdr.char_in),
    .end_of_field  (hdr.end_of_field),
    .char_out      (addr.char_out),
    .last_char     (addr.last_char),
    .empty_address (addr.empty_address),
    .truncated     (addr.truncated)
  );

  assign hdr.ready  = in_ready;
  assign addr.valid = out_valid;

endmodule
`default_nettype wire
